[hdl/fcct_pkg.sv]
package fcct_pkg;

	// counter and channel sizing
	localparam int CounterWidth = 16;
	localparam int NumChannels  = 4;
	localparam int ChannelSlots = 4;
	localparam int DataWidth    = 16;
	localparam int CompareWidth = (CounterWidth > DataWidth) ? CounterWidth : DataWidth;

	// bus operations
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} opcode_t;

	// register map
	typedef enum logic [3:0] {
		REG_CTRL    = 4'd0,
		REG_IRQ_EN  = 4'd1,
		REG_STATUS  = 4'd2,
		REG_COUNTER = 4'd3,
		REG_CMP0    = 4'd4,
		REG_CMP1    = 4'd5,
		REG_CMP2    = 4'd6,
		REG_CMP3    = 4'd7,
		REG_UPDATE  = 4'd8
	} reg_index_t;

	typedef logic [CounterWidth-1:0] count_t;
	typedef logic [DataWidth-1:0]    data_t;
	typedef logic [NumChannels-1:0]  chan_mask_t;

endpackage

[hdl/fcct_req_if.sv]
interface fcct_req_if;
	import fcct_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [3:0] reg_index;
	data_t      write_data;

	modport source (output valid, output opcode, output reg_index, output write_data,
		input ready);
	modport sink (input valid, input opcode, input reg_index, input write_data,
		output ready);
endinterface

[hdl/fcct_rsp_if.sv]
interface fcct_rsp_if;
	import fcct_pkg::*;

	logic       valid;
	logic       ready;
	data_t      read_data;
	logic       irq_pending;
	logic [1:0] pending_channel;
	logic       bad_access;

	modport source (output valid, output read_data, output irq_pending,
		output pending_channel, output bad_access, input ready);
	modport sink (input valid, input read_data, input irq_pending,
		input pending_channel, input bad_access, output ready);
endinterface

[hdl/four_channel_compare_timer.sv]
// Four-channel compare timer driven by a stream of bus transactions.
// Channel req carries one transaction per item: a tick, a register read or a
// register write (opcode, reg_index, write_data). Channel rsp returns exactly
// one result per transaction: read_data, irq_pending, pending_channel and
// bad_access, all taken from the timer state after that transaction.
// Path: a transaction is accepted into the input register, then the state
// update and result logic feed the result register, which offers it on rsp.
// Throughput: one transaction per cycle while rsp is not held off; the state
// update and the result logic sit in the single stage between the two
// registers, so each transaction sees the state left by the one before it.
// Reset: counter, compare values, flags, enables and run bit clear to zero;
// both registers are emptied and req.ready comes up high.
// Stall: while rsp is held off, the result register keeps its transaction,
// one more transaction can sit in the input register, then req.ready drops.
module four_channel_compare_timer (
	input  logic             clk,
	input  logic             arst_n,
	fcct_req_if.sink         req,
	fcct_rsp_if.source       rsp
);
	import fcct_pkg::*;

	// input register
	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic [3:0] reg_index_s1;
	data_t      write_data_s1;
	logic       go_s1;

	// timer state
	logic       run_q;
	chan_mask_t enable_q;
	chan_mask_t flags_q;
	count_t     count_q;
	data_t      compare_q [ChannelSlots];

	// next state and result
	logic       run_d;
	chan_mask_t enable_d;
	chan_mask_t flags_d;
	count_t     count_d;
	data_t      compare_d [ChannelSlots];
	data_t      read_data_d;
	logic       bad_d;
	logic       exists;
	chan_mask_t active;
	logic [1:0] chan_d;
	logic [1:0] cmp_sel;

	// result register
	logic       rsp_valid_q;
	data_t      read_data_q;
	logic       irq_q;
	logic [1:0] chan_q;
	logic       bad_q;

	// handshake
	assign go_s1     = valid_s1 & (~rsp_valid_q | rsp.ready);
	assign req.ready = ~valid_s1 | go_s1;
	assign cmp_sel   = reg_index_s1[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			opcode_s1     <= req.opcode;
			reg_index_s1  <= req.reg_index;
			write_data_s1 <= req.write_data;
		end
	end

	// register decode
	always_comb begin
		unique case (reg_index_s1)
			REG_CTRL, REG_IRQ_EN, REG_STATUS, REG_COUNTER, REG_UPDATE: exists = 1'b1;
			REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3:
				exists = ({2'b00, cmp_sel} < 4'(NumChannels));
			default: exists = 1'b0;
		endcase
	end

	// state update and result for one transaction
	always_comb begin
		run_d       = run_q;
		enable_d    = enable_q;
		flags_d     = flags_q;
		count_d     = count_q;
		compare_d   = compare_q;
		read_data_d = '0;
		bad_d       = 1'b0;
		unique case (opcode_s1)
			OP_TICK: begin
				if (run_q) begin
					count_d = count_q + 1'b1;
					for (int ch = 0; ch < NumChannels; ch++) begin
						if (CompareWidth'(count_d) == CompareWidth'(compare_q[ch])) begin
							flags_d[ch] = 1'b1;
						end
					end
				end
			end
			OP_READ: begin
				if (!exists) begin
					bad_d = 1'b1;
				end else begin
					unique case (reg_index_s1)
						REG_CTRL:    read_data_d = DataWidth'(run_q);
						REG_IRQ_EN:  read_data_d = DataWidth'(enable_q);
						REG_STATUS:  read_data_d = DataWidth'(flags_q);
						REG_COUNTER: read_data_d = DataWidth'(count_q);
						REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3:
							read_data_d = compare_q[cmp_sel];
						default:     read_data_d = '0;
					endcase
				end
			end
			OP_WRITE: begin
				if (!exists) begin
					bad_d = 1'b1;
				end else begin
					unique case (reg_index_s1)
						REG_CTRL:    run_d    = write_data_s1[0];
						REG_IRQ_EN:  enable_d = write_data_s1[NumChannels-1:0];
						REG_STATUS:  flags_d  = flags_q & write_data_s1[NumChannels-1:0];
						REG_COUNTER: count_d  = CounterWidth'(write_data_s1);
						REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3:
							compare_d[cmp_sel] = write_data_s1;
						REG_UPDATE:  count_d  = '0;
						default:     run_d    = run_q;
					endcase
				end
			end
			default: run_d = run_q;
		endcase

		// lowest enabled channel with its flag set
		active = flags_d & enable_d;
		chan_d = 2'd0;
		for (int i = NumChannels - 1; i >= 0; i--) begin
			if (active[i]) begin
				chan_d = 2'(i);
			end
		end
	end

	// timer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			enable_q  <= '0;
			flags_q   <= '0;
			count_q   <= '0;
			compare_q <= '{default: '0};
		end else if (go_s1) begin
			run_q     <= run_d;
			enable_q  <= enable_d;
			flags_q   <= flags_d;
			count_q   <= count_d;
			compare_q <= compare_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			read_data_q <= read_data_d;
			irq_q       <= |active;
			chan_q      <= chan_d;
			bad_q       <= bad_d;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.read_data       = read_data_q;
	assign rsp.irq_pending     = irq_q;
	assign rsp.pending_channel = chan_q;
	assign rsp.bad_access      = bad_q;

	// a stopped counter never moves on a tick
	a_stopped_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && opcode_s1 == OP_TICK && !run_q) |=> $stable(count_q))
		else $error("counter moved while stopped");

	// a bad access leaves the state alone
	a_bad_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && bad_d) |=> ($stable(flags_q) && $stable(enable_q) && $stable(run_q)))
		else $error("bad access changed state");

	// no interrupt means channel zero is reported
	a_chan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !irq_q) |-> (chan_q == 2'd0))
		else $error("pending channel set without interrupt");

	// a rejected access returns no data
	a_bad_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && bad_q) |-> (read_data_q == '0))
		else $error("bad access returned data");

endmodule

[test/four_channel_compare_timer_test.sv]
`timescale 1ns / 1ps

module four_channel_compare_timer_test;
	import fcct_pkg::*;

	// codes the package leaves unnamed
	localparam logic [1:0] OP_UNDEF      = 2'd3;
	localparam logic [3:0] REG_UNUSED_LO = 4'd9;
	localparam logic [3:0] REG_UNUSED_HI = 4'd15;

	localparam int RandomPerPhase = 220;
	localparam int HoldCycles     = 40;
	localparam int DrainCycles    = 8;
	localparam int MaxPrinted     = 40;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] reg_index;
		data_t      write_data;
	} bus_txn_t;

	typedef struct packed {
		data_t      read_data;
		logic       irq_pending;
		logic [1:0] pending_channel;
		logic       bad_access;
	} timer_result_t;

	typedef struct packed {
		bus_txn_t      txn;
		bit            typed;
		timer_result_t want;
	} directed_row_t;

	localparam timer_result_t Quiet     = '0;
	localparam timer_result_t BadAccess = '{16'h0000, 1'b0, 2'd0, 1'b1};
	localparam timer_result_t Predicted = '0;

	// directed walk: reset values, bad accesses, compare matches, wrap, update event
	localparam directed_row_t DirectedRows [25] = '{
		'{'{OP_READ,  REG_CTRL,      16'h0000}, 1'b1, Quiet},
		'{'{OP_READ,  REG_COUNTER,   16'h0000}, 1'b1, Quiet},
		'{'{OP_TICK,  REG_UNUSED_HI, 16'hFFFF}, 1'b1, Quiet},
		'{'{OP_READ,  REG_UNUSED_HI, 16'h0000}, 1'b1, BadAccess},
		'{'{OP_WRITE, REG_UNUSED_LO, 16'hFFFF}, 1'b1, BadAccess},
		'{'{OP_UNDEF, REG_CTRL,      16'hFFFF}, 1'b1, Quiet},
		'{'{OP_READ,  REG_CTRL,      16'h0000}, 1'b1, Quiet},
		'{'{OP_WRITE, REG_IRQ_EN,    16'hFFFF}, 1'b0, Predicted},
		'{'{OP_READ,  REG_IRQ_EN,    16'h0000}, 1'b0, Predicted},
		'{'{OP_WRITE, REG_CMP0,      16'h0002}, 1'b0, Predicted},
		'{'{OP_WRITE, REG_CMP3,      16'hFFFF}, 1'b0, Predicted},
		'{'{OP_WRITE, REG_CMP1,      16'h0001}, 1'b0, Predicted},
		'{'{OP_WRITE, REG_CTRL,      16'hFFFE}, 1'b0, Predicted},
		'{'{OP_WRITE, REG_CTRL,      16'h0001}, 1'b0, Predicted},
		'{'{OP_TICK,  REG_CTRL,      16'h0000}, 1'b0, Predicted},
		'{'{OP_TICK,  REG_STATUS,    16'h5A5A}, 1'b0, Predicted},
		'{'{OP_WRITE, REG_STATUS,    16'hFFFE}, 1'b0, Predicted},
		'{'{OP_WRITE, REG_STATUS,    16'h0000}, 1'b0, Predicted},
		'{'{OP_WRITE, REG_COUNTER,   16'hFFFE}, 1'b0, Predicted},
		'{'{OP_TICK,  REG_CTRL,      16'h0000}, 1'b0, Predicted},
		'{'{OP_TICK,  REG_CTRL,      16'h0000}, 1'b0, Predicted},
		'{'{OP_READ,  REG_STATUS,    16'h0000}, 1'b0, Predicted},
		'{'{OP_WRITE, REG_UPDATE,    16'h1234}, 1'b0, Predicted},
		'{'{OP_READ,  REG_UPDATE,    16'h0000}, 1'b0, Predicted},
		'{'{OP_READ,  REG_CMP3,      16'h0000}, 1'b0, Predicted}
	};

	logic clk;
	logic arst_n;

	fcct_req_if req ();
	fcct_rsp_if rsp ();

	four_channel_compare_timer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow copy of the timer state
	count_t     count_shadow;
	data_t      compare_shadow [ChannelSlots];
	chan_mask_t flag_shadow;
	chan_mask_t irq_en_shadow;
	logic       run_shadow;

	timer_result_t expected_results [$];
	timer_result_t oldest_result;
	int            mismatch_count;
	int            send_idle_pct;
	int            recv_idle_pct;
	int            hold_request;
	int            hold_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one transaction to the shadow state and return the result it produces
	function automatic timer_result_t timer_step(input bus_txn_t t);
		timer_result_t r;
		chan_mask_t    active;
		logic          reg_ok;
		r = '0;
		reg_ok = (t.reg_index <= REG_COUNTER) || (t.reg_index == REG_UPDATE) ||
			(t.reg_index >= REG_CMP0 && t.reg_index <= REG_CMP3 &&
			int'(t.reg_index - REG_CMP0) < NumChannels);
		if (t.opcode == OP_TICK) begin
			// stopped counter ignores ticks; a moving one sets flags on a match
			if (run_shadow) begin
				count_shadow = count_shadow + 1'b1;
				for (int ch = 0; ch < NumChannels; ch++) begin
					if (CompareWidth'(count_shadow) == CompareWidth'(compare_shadow[ch]))
						flag_shadow[ch] = 1'b1;
				end
			end
		end else if (t.opcode == OP_READ || t.opcode == OP_WRITE) begin
			if (!reg_ok) begin
				r.bad_access = 1'b1;
			end else if (t.opcode == OP_READ) begin
				case (t.reg_index)
					REG_CTRL:    r.read_data = data_t'(run_shadow);
					REG_IRQ_EN:  r.read_data = data_t'(irq_en_shadow);
					REG_STATUS:  r.read_data = data_t'(flag_shadow);
					REG_COUNTER: r.read_data = data_t'(count_shadow);
					REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3: begin
						r.read_data = compare_shadow[2'(t.reg_index - REG_CMP0)];
					end
					default:     r.read_data = '0;
				endcase
			end else begin
				case (t.reg_index)
					REG_CTRL:    run_shadow = t.write_data[0];
					REG_IRQ_EN:  irq_en_shadow = chan_mask_t'(t.write_data);
					REG_STATUS:  flag_shadow = flag_shadow & chan_mask_t'(t.write_data);
					REG_COUNTER: count_shadow = count_t'(t.write_data);
					REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3: begin
						compare_shadow[2'(t.reg_index - REG_CMP0)] = t.write_data;
					end
					REG_UPDATE:  count_shadow = '0;
					default:     ;
				endcase
			end
		end
		// lowest enabled flag wins
		active = flag_shadow & irq_en_shadow;
		r.irq_pending = |active;
		for (int ch = NumChannels - 1; ch >= 0; ch--) begin
			if (active[ch])
				r.pending_channel = 2'(ch);
		end
		return r;
	endfunction

	// random transaction, biased toward compare values just ahead of the counter
	function automatic bus_txn_t random_txn();
		bus_txn_t t;
		int       pick;
		pick = $urandom_range(99);
		t.write_data = data_t'($urandom());
		t.reg_index = 4'($urandom_range(15));
		if (pick < 50) begin
			t.opcode = OP_TICK;
		end else if (pick < 97) begin
			t.opcode = (pick < 72) ? OP_READ : OP_WRITE;
			if ($urandom_range(9) == 0)
				t.reg_index = 4'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
			else
				t.reg_index = 4'($urandom_range(REG_CTRL, REG_UPDATE));
			if (t.opcode == OP_WRITE) begin
				case (t.reg_index)
					REG_CTRL: t.write_data[0] = ($urandom_range(4) != 0);
					REG_COUNTER: begin
						if ($urandom_range(1) == 0)
							t.write_data = 16'hFFFF - data_t'($urandom_range(8));
					end
					REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3: begin
						if ($urandom_range(2) != 0)
							t.write_data = data_t'(count_shadow) + data_t'($urandom_range(1, 12));
					end
					default: ;
				endcase
			end
		end else begin
			t.opcode = OP_UNDEF;
		end
		return t;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		if (mismatch_count < MaxPrinted)
			$display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// offer one transaction after a random gap and record its expected result
	task automatic send_txn(input bus_txn_t t, input bit typed, input timer_result_t want);
		timer_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.opcode     <= t.opcode;
		req.reg_index  <= t.reg_index;
		req.write_data <= t.write_data;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		predicted = timer_step(t);
		expected_results.push_back(typed ? want : predicted);
	endtask

	// result side: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			rsp.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", rsp.read_data, 16'h0000);
			end else begin
				oldest_result = expected_results.pop_front();
				if (rsp.read_data !== oldest_result.read_data)
					report_mismatch("read_data", rsp.read_data, oldest_result.read_data);
				if (rsp.irq_pending !== oldest_result.irq_pending)
					report_mismatch("irq_pending", 16'(rsp.irq_pending),
						16'(oldest_result.irq_pending));
				if (rsp.pending_channel !== oldest_result.pending_channel)
					report_mismatch("pending_channel", 16'(rsp.pending_channel),
						16'(oldest_result.pending_channel));
				if (rsp.bad_access !== oldest_result.bad_access)
					report_mismatch("bad_access", 16'(rsp.bad_access),
						16'(oldest_result.bad_access));
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("four_channel_compare_timer verification failed");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.opcode     = OP_TICK;
		req.reg_index  = REG_CTRL;
		req.write_data = '0;
		rsp.ready      = 1'b0;
		count_shadow   = '0;
		flag_shadow    = '0;
		irq_en_shadow  = '0;
		run_shadow     = 1'b0;
		for (int ch = 0; ch < ChannelSlots; ch++)
			compare_shadow[ch] = '0;
		mismatch_count = 0;
		hold_request   = 0;
		hold_left      = 0;
		send_idle_pct  = 24;
		recv_idle_pct  = 59;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed transactions
		foreach (DirectedRows[i])
			send_txn(DirectedRows[i].txn, DirectedRows[i].typed, DirectedRows[i].want);

		// random transactions in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 59;
				end
				1: begin
					send_idle_pct = 59;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_request  = HoldCycles;
				end
			endcase
			repeat (RandomPerPhase)
				send_txn(random_txn(), 1'b0, Quiet);
		end

		// drain
		req.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("four_channel_compare_timer verification clean");
		end else begin
			$display("four_channel_compare_timer verification failed");
		end
		$finish;
	end

endmodule
